// ===== rtl/core/i2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and helpers for the roman numeral converter
// Symbol codes, item classes, the queue entry and the per-digit symbol rules.
// ----------------------------------------------------------------------------
package i2r_pkg;

	localparam int VALUE_W     = 12;
	localparam int SYM_W       = 3;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 8;
	localparam int OUT_USER_W  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

	// digit positions, thousands first
	localparam logic [1:0] POS_THOU = 2'd3;
	localparam logic [1:0] POS_HUND = 2'd2;
	localparam logic [1:0] POS_TENS = 2'd1;
	localparam logic [1:0] POS_UNIT = 2'd0;

	typedef enum logic [SYM_W-1:0] {
		SYM_I = 3'd0,
		SYM_V = 3'd1,
		SYM_X = 3'd2,
		SYM_L = 3'd3,
		SYM_C = 3'd4,
		SYM_D = 3'd5,
		SYM_M = 3'd6
	} sym_t;

	typedef enum logic [1:0] {
		KIND_NUM  = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_OVER = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} entry_t;

	// decade weight of a split position
	function automatic logic [VALUE_W-1:0] weight(input logic [1:0] pos);
		logic [VALUE_W-1:0] w;
		begin
			unique case (pos)
				POS_THOU: w = 12'd1000;
				POS_HUND: w = 12'd100;
				POS_TENS: w = 12'd10;
				default:  w = 12'd1;
			endcase
			return w;
		end
	endfunction

	// number of symbols a decimal digit turns into
	function automatic logic [2:0] sym_count(input logic [3:0] d);
		logic [2:0] n;
		begin
			unique case (d)
				4'd1, 4'd5:       n = 3'd1;
				4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
				4'd3, 4'd7:       n = 3'd3;
				4'd8:             n = 3'd4;
				default:          n = 3'd0;
			endcase
			return n;
		end
	endfunction

	// symbol k of digit d at a given position
	function automatic sym_t sym_pick(input logic [3:0] d, input logic [1:0] k,
			input logic [1:0] pos);
		sym_t one;
		sym_t five;
		sym_t ten;
		sym_t s;
		begin
			unique case (pos)
				POS_THOU: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
				POS_HUND: begin one = SYM_C; five = SYM_D; ten = SYM_M; end
				POS_TENS: begin one = SYM_X; five = SYM_L; ten = SYM_C; end
				default:  begin one = SYM_I; five = SYM_V; ten = SYM_X; end
			endcase
			priority if (d < 4'd4) begin
				s = one;
			end else if (d == 4'd4) begin
				s = (k == 2'd0) ? one : five;
			end else if (d < 4'd9) begin
				s = (k == 2'd0) ? five : one;
			end else begin
				s = (k == 2'd0) ? one : ten;
			end
			return s;
		end
	endfunction

endpackage

// ===== rtl/core/i2r_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_front: input side of the roman numeral converter
// Takes a value, classifies it and splits it into decimal digits.
// ----------------------------------------------------------------------------
module i2r_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [i2r_pkg::IN_DATA_W-1:0]   s_tdata,   // [11:0] value
	output logic                            push_valid,
	input  logic                            push_ready,
	output i2r_pkg::entry_t                 push_entry
);

	typedef enum logic [2:0] {
		F_IDLE  = 3'b001,
		F_SPLIT = 3'b010,
		F_PUSH  = 3'b100
	} front_state_t;

	front_state_t                     state_q;
	logic [i2r_pkg::VALUE_W-1:0]      rem_q;
	logic [1:0]                       pos_q;
	i2r_pkg::entry_t                  entry_q;

	logic [i2r_pkg::VALUE_W-1:0]      value;
	logic [i2r_pkg::VALUE_W-1:0]      w_sel;
	logic [i2r_pkg::VALUE_W+1:0]      thr;
	logic [3:0]                       dig;
	logic [i2r_pkg::VALUE_W-1:0]      sub;
	logic [i2r_pkg::VALUE_W-1:0]      rem_next;

	assign value      = s_tdata[i2r_pkg::VALUE_W-1:0];
	assign s_tready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_entry = entry_q;

	// one decimal digit per cycle: largest multiple of the weight that fits
	always_comb begin
		w_sel = i2r_pkg::weight(pos_q);
		thr   = '0;
		dig   = '0;
		sub   = '0;
		for (int d = 1; d <= 9; d++) begin
			thr = 14'(d) * {2'b00, w_sel};
			if ({2'b00, rem_q} >= thr) begin
				dig = 4'(d);
				sub = thr[i2r_pkg::VALUE_W-1:0];
			end
		end
		rem_next = rem_q - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						if (value == '0 || value > i2r_pkg::MAX_VALID) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_SPLIT;
						end
					end
				end
				F_SPLIT: begin
					if (pos_q == i2r_pkg::POS_TENS) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_tvalid) begin
			rem_q <= value;
			pos_q <= i2r_pkg::POS_THOU;
			if (value == '0) begin
				entry_q.kind <= i2r_pkg::KIND_ZERO;
			end else if (value > i2r_pkg::MAX_VALID) begin
				entry_q.kind <= i2r_pkg::KIND_OVER;
			end else begin
				entry_q.kind <= i2r_pkg::KIND_NUM;
			end
		end else if (state_q == F_SPLIT) begin
			rem_q <= rem_next;
			pos_q <= pos_q - 2'd1;
			unique case (pos_q)
				i2r_pkg::POS_THOU: entry_q.thou <= dig[1:0];
				i2r_pkg::POS_HUND: entry_q.hund <= dig;
				default: begin
					entry_q.tens  <= dig;
					entry_q.units <= rem_next[3:0];
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/i2r_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_queue: short queue between digit split and symbol emit
// Small register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module i2r_queue #(
	parameter int DEPTH = i2r_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  i2r_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output i2r_pkg::entry_t pop_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	i2r_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/i2r_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_back: symbol emitter of the roman numeral converter
// Walks the digits of one entry and sends one symbol per word.
// ----------------------------------------------------------------------------
module i2r_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  i2r_pkg::entry_t                  pop_entry,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [i2r_pkg::OUT_DATA_W-1:0]   m_tdata,   // [2:0] symbol
	output logic                             m_tlast,
	output logic [i2r_pkg::OUT_USER_W-1:0]   m_tuser    // [0] empty_res, [1] out_of_range
);

	i2r_pkg::entry_t  cur_q;
	logic             busy_q;
	logic [1:0]       pos_q;
	logic [1:0]       k_q;

	logic             out_valid_q;
	i2r_pkg::sym_t    out_sym_q;
	logic             out_last_q;
	logic             out_empty_q;
	logic             out_over_q;

	logic [3:0]       cur_d;
	logic [2:0]       n_sym;
	logic             lower_zero;
	logic             can_emit;
	logic             step;
	logic             digit_done;

	assign pop_ready = !busy_q;
	assign can_emit  = !out_valid_q || m_tready;
	assign step      = busy_q && can_emit;

	always_comb begin
		unique case (pos_q)
			i2r_pkg::POS_THOU: begin
				cur_d      = {2'b00, cur_q.thou};
				lower_zero = (cur_q.hund == '0) && (cur_q.tens == '0) && (cur_q.units == '0);
			end
			i2r_pkg::POS_HUND: begin
				cur_d      = cur_q.hund;
				lower_zero = (cur_q.tens == '0) && (cur_q.units == '0);
			end
			i2r_pkg::POS_TENS: begin
				cur_d      = cur_q.tens;
				lower_zero = (cur_q.units == '0);
			end
			default: begin
				cur_d      = cur_q.units;
				lower_zero = 1'b1;
			end
		endcase
		n_sym      = i2r_pkg::sym_count(cur_d);
		digit_done = ({1'b0, k_q} == n_sym - 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word loads the output register, otherwise a taken word clears it
			if (step && (cur_q.kind != i2r_pkg::KIND_NUM || n_sym != '0)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				busy_q <= pop_valid;
			end else if (step) begin
				if (cur_q.kind != i2r_pkg::KIND_NUM) begin
					busy_q <= 1'b0;
				end else if (n_sym != '0 && digit_done && lower_zero) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			cur_q <= pop_entry;
			pos_q <= i2r_pkg::POS_THOU;
			k_q   <= '0;
		end else if (step) begin
			if (cur_q.kind != i2r_pkg::KIND_NUM) begin
				out_sym_q   <= i2r_pkg::SYM_I;
				out_last_q  <= 1'b1;
				out_empty_q <= (cur_q.kind == i2r_pkg::KIND_ZERO);
				out_over_q  <= (cur_q.kind == i2r_pkg::KIND_OVER);
			end else if (n_sym == '0) begin
				pos_q <= pos_q - 2'd1;
				k_q   <= '0;
			end else begin
				out_sym_q   <= i2r_pkg::sym_pick(cur_d, k_q, pos_q);
				out_last_q  <= digit_done && lower_zero;
				out_empty_q <= 1'b0;
				out_over_q  <= 1'b0;
				if (digit_done) begin
					pos_q <= pos_q - 2'd1;
					k_q   <= '0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(i2r_pkg::OUT_DATA_W - i2r_pkg::SYM_W){1'b0}}, out_sym_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_over_q, out_empty_q};

endmodule

// ===== rtl/core/integer_to_roman_numeral.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: integer to roman numeral stream converter
// Turns a 12-bit unsigned value into a run of roman symbol words.
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------------
// s        | in  | s_tvalid/s_tready  | s_tdata[11:0] value
// m        | out | m_tvalid/m_tready  | m_tdata[2:0] symbol, m_tlast last,
//          |     |                    | m_tuser[0] empty_res, m_tuser[1] out_of_range
//
// the front accepts a value, splits it over three digit-split steps with one bank
// of constant compares, then pushes it to the queue, and takes no new value until
// the push is taken; flagged values skip the split
// the back loads an entry, then emits one symbol word per cycle while m_tready
// lets it and steps over each zero digit ahead of the last symbol; a flagged
// value gives a single word; the slower side sets the sustained rate: the back
// for long numerals, the front for short ones
// a queue of QUEUE_DEPTH entries lets the front split the next value while the
// back is still emitting; an output register holds each word under m_tready low
// reset clears all control state; no state survives between values
//
module integer_to_roman_numeral #(
	parameter int QUEUE_DEPTH = i2r_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [i2r_pkg::IN_DATA_W-1:0]   s_tdata,   // [11:0] value
	// output words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [i2r_pkg::OUT_DATA_W-1:0]  m_tdata,   // [2:0] symbol
	output logic                            m_tlast,
	output logic [i2r_pkg::OUT_USER_W-1:0]  m_tuser    // [0] empty_res, [1] out_of_range
);

	// front to queue
	logic            push_valid;
	logic            push_ready;
	i2r_pkg::entry_t push_entry;

	// queue to back
	logic            pop_valid;
	logic            pop_ready;
	i2r_pkg::entry_t pop_entry;

	// classify and split into digits
	i2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// decouples split from emit
	i2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// walk the digits, at most one symbol word per cycle as m_tready allows
	i2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTH
	// a word is never both empty and out of range
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("empty and out-of-range flags both set");

	// a flagged word closes its run and carries symbol zero
	a_flag_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != '0)) |-> (m_tlast && (m_tdata == '0)))
		else $error("flagged word not a lone last word");

	// symbol code seven is never produced
	a_sym_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd7))
		else $error("illegal symbol code");
`endif

endmodule

// ===== sim/integer_to_roman_numeral_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb: self-checking bench for the roman converter
// Streams directed and random values into the converter and checks every
// symbol word against a predicted numeral, with bursty input, a stalling
// output side and long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_tb;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 3;
	localparam int RANDOM_N    = 450;
	localparam int IDLE_LIMIT  = 4000;   // cycles with no word moving on either side
	localparam int DRAIN_CYC   = 64;     // settle time after the last expected word
	localparam int HOLD_CYC    = 400;    // long output hold-off
	localparam int MODE_CYC    = 50;     // cycles per output stall mode
	localparam int MAX_REPORTS = 10;

	// output stall modes
	typedef enum logic [1:0] {
		RDY_ALWAYS = 2'd0,
		RDY_COIN   = 2'd1,
		RDY_PERIOD = 2'd2,
		RDY_SPARSE = 2'd3
	} rdy_mode_t;

	// one expected symbol word
	typedef struct packed {
		i2r_pkg::sym_t symbol;
		logic          last;
		logic          empty_res;
		logic          out_of_range;
	} roman_word_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [i2r_pkg::IN_DATA_W-1:0]  s_tdata  = '0;      // [11:0] value
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [i2r_pkg::OUT_DATA_W-1:0] m_tdata;            // [2:0] symbol
	logic                           m_tlast;
	logic [i2r_pkg::OUT_USER_W-1:0] m_tuser;            // [0] empty_res, [1] out_of_range

	logic [i2r_pkg::VALUE_W-1:0] value_q[$];     // values waiting to be sent
	roman_word_t                 numeral_q[$];   // predicted words not yet seen
	int                          mismatches  = 0;
	int                          idle_cycles = 0;

	integer_to_roman_numeral u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// numeral predictor
	// ------------------------------------------------------------------

	task automatic push_symbol(input i2r_pkg::sym_t s);
		roman_word_t w;
		w.symbol       = s;
		w.last         = 1'b0;
		w.empty_res    = 1'b0;
		w.out_of_range = 1'b0;
		numeral_q.push_back(w);
	endtask

	// one decimal digit with its one, five and ten symbols
	task automatic push_digit(input int d, input i2r_pkg::sym_t one,
			input i2r_pkg::sym_t five, input i2r_pkg::sym_t ten);
		int n;
		if (d >= 1 && d <= 3) begin
			for (n = 0; n < d; n++) push_symbol(one);
		end else if (d == 4) begin
			push_symbol(one);
			push_symbol(five);
		end else if (d >= 5 && d <= 8) begin
			push_symbol(five);
			for (n = 5; n < d; n++) push_symbol(one);
		end else if (d == 9) begin
			push_symbol(one);
			push_symbol(ten);
		end
	endtask

	// expected words for one accepted value
	task automatic expand_value(input logic [i2r_pkg::VALUE_W-1:0] v);
		roman_word_t w;
		int          val;
		int          n;
		val = v;
		if (v == '0 || v > i2r_pkg::MAX_VALID) begin
			// zero and out-of-range values give a single flagged word with symbol code zero
			w.symbol       = i2r_pkg::SYM_I;
			w.last         = 1'b1;
			w.empty_res    = (v == '0);
			w.out_of_range = (v != '0);
			numeral_q.push_back(w);
		end else begin
			for (n = 0; n < val / 1000; n++) push_symbol(i2r_pkg::SYM_M);
			push_digit((val / 100) % 10, i2r_pkg::SYM_C, i2r_pkg::SYM_D, i2r_pkg::SYM_M);
			push_digit((val / 10) % 10, i2r_pkg::SYM_X, i2r_pkg::SYM_L, i2r_pkg::SYM_C);
			push_digit(val % 10, i2r_pkg::SYM_I, i2r_pkg::SYM_V, i2r_pkg::SYM_X);
			// mark the closing symbol of the run
			w = numeral_q.pop_back();
			w.last = 1'b1;
			numeral_q.push_back(w);
		end
	endtask

	// ------------------------------------------------------------------
	// random values
	// ------------------------------------------------------------------

	// a digit that expands to many symbols
	function automatic int heavy_digit();
		int r;
		r = $urandom_range(0, 2);
		return (r == 0) ? 3 : ((r == 1) ? 7 : 8);
	endfunction

	function automatic logic [i2r_pkg::VALUE_W-1:0] random_value();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			v = 0;
		end else if (r < 13) begin
			v = $urandom_range(4000, 4095);
		end else if (r < 33) begin
			// long numerals, mostly close to the 15-symbol worst case
			v = $urandom_range(1, 3) * 1000 + heavy_digit() * 100
				+ heavy_digit() * 10 + heavy_digit();
		end else if (r < 45) begin
			// values with inner zero digits
			v = $urandom_range(1, 3) * 1000 + $urandom_range(0, 1) * 100 * $urandom_range(0, 9)
				+ $urandom_range(0, 9);
		end else begin
			v = $urandom_range(1, 3999);
		end
		return v[i2r_pkg::VALUE_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// input driver: bursts of random length with random gaps
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : sender
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// predict the word run as soon as the value is taken
			if (s_tvalid && s_tready) begin
				expand_value(value_q.pop_front());
			end
			// an offered word stays put until it is taken
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (value_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(i2r_pkg::IN_DATA_W-i2r_pkg::VALUE_W){1'b0}}, value_q[0]};
					if (burst_left <= 1) begin
						// some bursts are long runs with no idling at all
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 8);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output monitor and stall pattern
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string what, input roman_word_t w);
		if (mismatches < MAX_REPORTS) begin
			$display("[%0t] %s: expected sym=%0d last=%0b empty=%0b over=%0b,",
				$realtime, what, w.symbol, w.last, w.empty_res, w.out_of_range,
				" got sym=%0d last=%0b user=%b",
				m_tdata[i2r_pkg::SYM_W-1:0], m_tlast, m_tuser);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : receiver
		roman_word_t w;
		int          words_seen;
		int          hold_left;
		int          holds_done;
		int          phase;
		rdy_mode_t   mode;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			words_seen = 0;
			hold_left  = 0;
			holds_done = 0;
			phase      = 0;
			mode       = RDY_ALWAYS;
		end else begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (numeral_q.size() == 0) begin
					w = '0;
					note_mismatch("unexpected word", w);
				end else begin
					w = numeral_q.pop_front();
					if (m_tdata[i2r_pkg::SYM_W-1:0] !== w.symbol || m_tlast !== w.last
							|| m_tuser[0] !== w.empty_res || m_tuser[1] !== w.out_of_range) begin
						note_mismatch("word mismatch", w);
					end
				end
			end
			// periodically pick a new random stall flavor
			phase++;
			if (phase % MODE_CYC == 0) begin
				mode = rdy_mode_t'($urandom_range(0, 3));
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if ((holds_done == 0 && words_seen >= 150)
					|| (holds_done == 1 && words_seen >= 2000)) begin
				// long hold-off: the sender keeps offering and the block backs up
				holds_done++;
				hold_left = HOLD_CYC;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RDY_ALWAYS: m_tready <= 1'b1;
					RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RDY_PERIOD: m_tready <= (phase % 4 != 3);
					default:    m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles in which no word moves on either side
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------

	initial begin : stimulus
		int n;
		// extremes, each subtractive form, five-plus-ones, inner zeros, flags
		value_q = '{12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10,
			12'd40, 12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd505, 12'd900,
			12'd999, 12'd1000, 12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd4000,
			12'd4095};
		for (n = 0; n < RANDOM_N; n++) value_q.push_back(random_value());

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		while (!(value_q.size() == 0 && numeral_q.size() == 0) && idle_cycles < IDLE_LIMIT)
			@(posedge clk);

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			// stray words after the last expected one still count here
			repeat (DRAIN_CYC) @(posedge clk);
			if (mismatches == 0) begin
				$display("Testbench completed without errors");
			end else begin
				$display("Testbench completed WITH ERRORS");
			end
			$finish;
		end
	end

endmodule
